>>> hdl/assert_macros.svh
// Assertion macros for the design files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Clocked property that must never hold, switched off while reset is high.
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");

`endif

>>> hdl/gfpe_pkg.sv
// Package for the GF(2^8) parity encoder: sizes, register indexes, types and the field multiply.
package gfpe_pkg;

   localparam int DataLanes   = 8;
   localparam int ParityLanes = 4;
   localparam int MaxData     = 8;
   localparam int MaxParity   = 4;

   localparam int DataLimInt   = (MaxData < DataLanes) ? MaxData : DataLanes;
   localparam int ParityLimInt = (MaxParity < ParityLanes) ? MaxParity : ParityLanes;

   localparam int DataCountW   = 4;
   localparam int ParityCountW = 3;
   localparam int CsrIndexW    = 3;
   localparam int CsrDataW     = 64;

   localparam logic [DataCountW-1:0]   DataLim   = DataCountW'(DataLimInt);
   localparam logic [ParityCountW-1:0] ParityLim = ParityCountW'(ParityLimInt);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_DATA_COUNT   = 3'd0,
      CSR_PARITY_COUNT = 3'd1,
      CSR_COEF_ROW0    = 3'd2,
      CSR_COEF_ROW1    = 3'd3,
      CSR_COEF_ROW2    = 3'd4,
      CSR_COEF_ROW3    = 3'd5,
      CSR_FIELD_POLY   = 3'd6
   } csr_index_type;

   typedef logic [ParityLanes-1:0][7:0] row_bytes_type;
   typedef row_bytes_type [DataLanes-1:0] lane_prods_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // Shift-and-reduce product; the polynomial need not be irreducible.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] poly);
      logic [7:0] acc;
      logic [7:0] aa;
      acc = 8'h00;
      aa  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ aa;
         end
         aa = aa[7] ? ({aa[6:0], 1'b0} ^ poly) : {aa[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

>>> hdl/gfpe_lane.sv
// One data lane: multiplies its byte by the coefficient of every parity row.
module gfpe_lane (
   input  logic                  clock,
   input  logic [7:0]            data,
   input  gfpe_pkg::row_bytes_type coef,
   input  logic [7:0]            poly,
   input  logic                  enable,
   output gfpe_pkg::row_bytes_type prod_ff
);

   gfpe_pkg::row_bytes_type prod_in;

   always_comb begin
      for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
         prod_in[r] = enable ? gfpe_pkg::gf_mul(data, coef[r], poly) : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> hdl/gfpe_merge.sv
// Merge stage: folds the lane products into one parity byte per row and registers the result.
module gfpe_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  gfpe_pkg::ctl_type          ctl,
   input  gfpe_pkg::lane_prods_type   prods,
   input  logic [gfpe_pkg::ParityLanes-1:0] row_en,
   output gfpe_pkg::ctl_type          ctl_ff,
   output gfpe_pkg::row_bytes_type    parity_ff
);

   gfpe_pkg::row_bytes_type parity_in;

   always_comb begin
      for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
         parity_in[r] = 8'h00;
         for (int j = 0; j < gfpe_pkg::DataLanes; j++) begin
            parity_in[r] = parity_in[r] ^ prods[j][r];
         end
         if (!row_en[r]) begin
            parity_in[r] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      parity_ff <= parity_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

endmodule

>>> hdl/gf256_erasure_parity_encoder_unit.sv
// Top level of the GF(2^8) erasure parity encoder: registers, lanes and merge stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   request  | start, busy          | req_data_lane0..7, req_in_last
//   response | rsp_valid (strobe)   | rsp_parity_lane0..3, rsp_out_last
//   csr      | csr_valid, csr_ready | csr_index, csr_data
//
// A beat is taken at every edge with start high and busy low, so one byte position
// enters each cycle. Its parity is registered in the lane multipliers and then in
// the XOR merge. busy is high only during reset; reset clears the registers to their
// defaults and empties the pipeline. The response side has no back-pressure, and
// csr_ready is always high.
`include "assert_macros.svh"

module gf256_erasure_parity_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_data_lane0,
   input  logic [7:0]  req_data_lane1,
   input  logic [7:0]  req_data_lane2,
   input  logic [7:0]  req_data_lane3,
   input  logic [7:0]  req_data_lane4,
   input  logic [7:0]  req_data_lane5,
   input  logic [7:0]  req_data_lane6,
   input  logic [7:0]  req_data_lane7,
   input  logic        req_in_last,
   output logic        rsp_valid,
   output logic [7:0]  rsp_parity_lane0,
   output logic [7:0]  rsp_parity_lane1,
   output logic [7:0]  rsp_parity_lane2,
   output logic [7:0]  rsp_parity_lane3,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [gfpe_pkg::CsrIndexW-1:0] csr_index,
   input  logic [gfpe_pkg::CsrDataW-1:0]  csr_data
);

   logic [gfpe_pkg::DataCountW-1:0]   data_count_ff;
   logic [gfpe_pkg::ParityCountW-1:0] parity_count_ff;
   logic [gfpe_pkg::ParityLanes-1:0][gfpe_pkg::CsrDataW-1:0] coef_row_ff;
   logic [7:0]                        poly_ff;

   logic                              accept;
   logic [gfpe_pkg::DataCountW-1:0]   k_eff;
   logic [gfpe_pkg::ParityCountW-1:0] m_eff;
   logic [gfpe_pkg::DataLanes-1:0]    lane_en;
   logic [gfpe_pkg::ParityLanes-1:0]  row_en;
   logic [gfpe_pkg::DataLanes-1:0][7:0] data;
   gfpe_pkg::lane_prods_type          lane_coef;
   gfpe_pkg::lane_prods_type          prods;
   gfpe_pkg::ctl_type                 ctl_ff;
   gfpe_pkg::ctl_type                 ctl_in;
   gfpe_pkg::ctl_type                 out_ctl;
   gfpe_pkg::row_bytes_type           parity;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_count_ff   <= gfpe_pkg::DataCountW'(8);
         parity_count_ff <= gfpe_pkg::ParityCountW'(4);
         coef_row_ff     <= '0;
         poly_ff         <= 8'd29;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gfpe_pkg::CSR_DATA_COUNT: begin
               data_count_ff <= csr_data[gfpe_pkg::DataCountW-1:0];
            end
            gfpe_pkg::CSR_PARITY_COUNT: begin
               parity_count_ff <= csr_data[gfpe_pkg::ParityCountW-1:0];
            end
            gfpe_pkg::CSR_COEF_ROW0: coef_row_ff[0] <= csr_data;
            gfpe_pkg::CSR_COEF_ROW1: coef_row_ff[1] <= csr_data;
            gfpe_pkg::CSR_COEF_ROW2: coef_row_ff[2] <= csr_data;
            gfpe_pkg::CSR_COEF_ROW3: coef_row_ff[3] <= csr_data;
            gfpe_pkg::CSR_FIELD_POLY: poly_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Counts above the lane limits saturate; zero switches everything off.
   assign k_eff = (data_count_ff < gfpe_pkg::DataLim) ? data_count_ff : gfpe_pkg::DataLim;
   assign m_eff = (parity_count_ff < gfpe_pkg::ParityLim) ? parity_count_ff
                                                           : gfpe_pkg::ParityLim;

   assign data = {req_data_lane7, req_data_lane6, req_data_lane5, req_data_lane4,
                  req_data_lane3, req_data_lane2, req_data_lane1, req_data_lane0};

   always_comb begin
      for (int j = 0; j < gfpe_pkg::DataLanes; j++) begin
         lane_en[j] = gfpe_pkg::DataCountW'(j) < k_eff;
         for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
            lane_coef[j][r] = coef_row_ff[r][8*j +: 8];
         end
      end
      for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
         row_en[r] = gfpe_pkg::ParityCountW'(r) < m_eff;
      end
   end

   for (genvar j = 0; j < gfpe_pkg::DataLanes; j++) begin : g_lane
      gfpe_lane u_lane (
         .clock   (clock),
         .data    (data[j]),
         .coef    (lane_coef[j]),
         .poly    (poly_ff),
         .enable  (lane_en[j]),
         .prod_ff (prods[j])
      );
   end

   assign ctl_in.valid = accept;
   assign ctl_in.last  = req_in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   gfpe_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_ff),
      .prods     (prods),
      .row_en    (row_en),
      .ctl_ff    (out_ctl),
      .parity_ff (parity)
   );

   assign rsp_valid        = out_ctl.valid;
   assign rsp_out_last     = out_ctl.last;
   assign rsp_parity_lane0 = parity[0];
   assign rsp_parity_lane1 = parity[1];
   assign rsp_parity_lane2 = parity[2];
   assign rsp_parity_lane3 = parity[3];

   // Every accepted beat gives exactly one strobe, after the lane and merge registers, carrying its last flag.
   `ASSERT_CLK(a_rsp_follows_accept, clock, reset, accept |=> ##1 rsp_valid)
   `ASSERT_CLK(a_rsp_only_after_accept, clock, reset, rsp_valid |-> $past(accept, 2))
   `ASSERT_CLK(a_last_carried, clock, reset, accept |=> ##1 (rsp_out_last == $past(req_in_last, 2)))
   // With fewer than four rows active the top parity byte must be zero.
   `ASSERT_NEVER(a_idle_row_zero, clock, reset,
                 rsp_valid && !row_en[3] && (rsp_parity_lane3 != 8'h00))

endmodule

>>> tb/sv/tb_gf256_erasure_parity_encoder_unit.sv
// Self-checking testbench for the GF(2^8) erasure parity encoder top level.
`timescale 1ns / 1ps

module tb_gf256_erasure_parity_encoder_unit;

   localparam int RandomBeats = 830;
   localparam logic [gfpe_pkg::CsrIndexW-1:0] CsrIndexUnmapped = 3'd7;

   typedef struct packed {
      logic [gfpe_pkg::DataLanes-1:0][7:0] bytes;
      logic                                last;
   } stripe_beat_type;

   typedef struct packed {
      logic [gfpe_pkg::ParityLanes-1:0][7:0] parity;
      logic                                  last;
   } parity_beat_type;

   typedef struct {
      parity_beat_type value;
      time             accepted_at;
   } parity_due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_data_lane0 = '0;
   logic [7:0] req_data_lane1 = '0;
   logic [7:0] req_data_lane2 = '0;
   logic [7:0] req_data_lane3 = '0;
   logic [7:0] req_data_lane4 = '0;
   logic [7:0] req_data_lane5 = '0;
   logic [7:0] req_data_lane6 = '0;
   logic [7:0] req_data_lane7 = '0;
   logic req_in_last = 1'b0;
   logic rsp_valid;
   logic [7:0] rsp_parity_lane0;
   logic [7:0] rsp_parity_lane1;
   logic [7:0] rsp_parity_lane2;
   logic [7:0] rsp_parity_lane3;
   logic rsp_out_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gfpe_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [gfpe_pkg::CsrDataW-1:0] csr_data = '0;

   // Register copy held by the predictor, at reset values.
   logic [gfpe_pkg::DataCountW-1:0]   cfg_data_count = 4'd8;
   logic [gfpe_pkg::ParityCountW-1:0] cfg_parity_count = 3'd4;
   logic [63:0]                       cfg_coef [gfpe_pkg::ParityLanes] = '{default: '0};
   logic [7:0]                        cfg_poly = 8'h1D;

   stripe_beat_type pending_beats [$];
   parity_due_type  parity_due [$];
   stripe_beat_type on_port;
   int              hold_off = 0;
   bit              steady_flow = 1'b0;
   int              mismatch_count = 0;

   gf256_erasure_parity_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_lane0   (req_data_lane0),
      .req_data_lane1   (req_data_lane1),
      .req_data_lane2   (req_data_lane2),
      .req_data_lane3   (req_data_lane3),
      .req_data_lane4   (req_data_lane4),
      .req_data_lane5   (req_data_lane5),
      .req_data_lane6   (req_data_lane6),
      .req_data_lane7   (req_data_lane7),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_parity_lane0 (rsp_parity_lane0),
      .rsp_parity_lane1 (rsp_parity_lane1),
      .rsp_parity_lane2 (rsp_parity_lane2),
      .rsp_parity_lane3 (rsp_parity_lane3),
      .rsp_out_last     (rsp_out_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Horner form: walk the coefficient from its top bit, doubling the sum each step.
   function automatic logic [7:0] field_product(input logic [7:0] coef, input logic [7:0] value);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         sum = sum[7] ? ({sum[6:0], 1'b0} ^ cfg_poly) : {sum[6:0], 1'b0};
         if (coef[i]) begin
            sum = sum ^ value;
         end
      end
      return sum;
   endfunction

   function automatic parity_beat_type encode_parity(input stripe_beat_type beat);
      parity_beat_type res;
      int k;
      int m;
      logic [7:0] acc;
      k = (int'(cfg_data_count) < gfpe_pkg::DataLimInt) ? int'(cfg_data_count)
                                                        : gfpe_pkg::DataLimInt;
      m = (int'(cfg_parity_count) < gfpe_pkg::ParityLimInt) ? int'(cfg_parity_count)
                                                            : gfpe_pkg::ParityLimInt;
      for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
         acc = 8'h00;
         if (r < m) begin
            for (int j = 0; j < k; j++) begin
               acc = acc ^ field_product(cfg_coef[r][8*j +: 8], beat.bytes[j]);
            end
         end
         res.parity[r] = acc;
      end
      res.last = beat.last;
      return res;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] random_row();
      logic [63:0] row;
      row = '0;
      if ($urandom_range(0, 7) != 0) begin
         for (int j = 0; j < 8; j++) begin
            row[8*j +: 8] = pick_byte();
         end
      end
      return row;
   endfunction

   task automatic queue_beat(input logic [gfpe_pkg::DataLanes-1:0][7:0] bytes,
                             input logic last);
      stripe_beat_type beat;
      beat.bytes = bytes;
      beat.last  = last;
      pending_beats.push_back(beat);
   endtask

   task automatic queue_random_beat();
      logic [gfpe_pkg::DataLanes-1:0][7:0] bytes;
      for (int j = 0; j < gfpe_pkg::DataLanes; j++) begin
         bytes[j] = pick_byte();
      end
      queue_beat(bytes, $urandom_range(0, 7) == 0);
   endtask

   // Called just after a rising edge; leaves csr_valid high for the caller to drop.
   task automatic csr_write(input logic [gfpe_pkg::CsrIndexW-1:0] idx,
                            input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gfpe_pkg::CSR_DATA_COUNT:   cfg_data_count = value[gfpe_pkg::DataCountW-1:0];
         gfpe_pkg::CSR_PARITY_COUNT: cfg_parity_count = value[gfpe_pkg::ParityCountW-1:0];
         gfpe_pkg::CSR_COEF_ROW0:    cfg_coef[0] = value;
         gfpe_pkg::CSR_COEF_ROW1:    cfg_coef[1] = value;
         gfpe_pkg::CSR_COEF_ROW2:    cfg_coef[2] = value;
         gfpe_pkg::CSR_COEF_ROW3:    cfg_coef[3] = value;
         gfpe_pkg::CSR_FIELD_POLY:   cfg_poly = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [63:0] k_word, input logic [63:0] m_word,
                                input logic [63:0] r0, input logic [63:0] r1,
                                input logic [63:0] r2, input logic [63:0] r3,
                                input logic [63:0] poly_word, input bit poke_unmapped);
      if (poke_unmapped) begin
         csr_write(CsrIndexUnmapped, {$urandom, $urandom});
      end
      csr_write(gfpe_pkg::CSR_DATA_COUNT, k_word);
      csr_write(gfpe_pkg::CSR_PARITY_COUNT, m_word);
      csr_write(gfpe_pkg::CSR_COEF_ROW0, r0);
      csr_write(gfpe_pkg::CSR_COEF_ROW1, r1);
      csr_write(gfpe_pkg::CSR_COEF_ROW2, r2);
      csr_write(gfpe_pkg::CSR_COEF_ROW3, r3);
      csr_write(gfpe_pkg::CSR_FIELD_POLY, poly_word);
      csr_valid <= 1'b0;
   endtask

   task automatic randomize_registers(input bit poke_unmapped);
      logic [63:0] k_word;
      logic [63:0] m_word;
      logic [63:0] poly_word;
      case ($urandom_range(0, 7))
         0: k_word = 64'd0;
         1: k_word = 64'd1;
         2: k_word = 64'd8;
         3: k_word = 64'($urandom_range(9, 15));
         default: k_word = 64'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
         0: m_word = 64'd0;
         1: m_word = 64'd1;
         2: m_word = 64'd4;
         3: m_word = 64'($urandom_range(5, 7));
         default: m_word = 64'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
         0, 1: poly_word = 64'h1D;
         2: poly_word = 64'h00;
         3: poly_word = 64'hFF;
         default: poly_word = 64'($urandom_range(0, 255));
      endcase
      // Now and then the unused upper bits carry junk, which the registers drop.
      if ($urandom_range(0, 3) == 0) begin
         k_word    = k_word | ({$urandom, $urandom} & ~64'hF);
         m_word    = m_word | ({$urandom, $urandom} & ~64'h7);
         poly_word = poly_word | ({$urandom, $urandom} & ~64'hFF);
      end
      set_registers(k_word, m_word, random_row(), random_row(), random_row(), random_row(),
                    poly_word, poke_unmapped);
   endtask

   // Returns just after a rising edge once every beat has gone in and its parity come back.
   task automatic wait_idle();
      while (pending_beats.size() != 0 || start || parity_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_beats
      stripe_beat_type beat;
      parity_due_type  due;
      if (reset) begin
         start    <= 1'b0;
         hold_off <= 0;
      end else begin
         if (start && !busy) begin
            due.value       = encode_parity(on_port);
            due.accepted_at = $time;
            parity_due.push_back(due);
         end
         if (start && busy) begin
            // The beat stays on the ports until it is taken.
         end else if (hold_off > 0) begin
            start    <= 1'b0;
            hold_off <= hold_off - 1;
         end else if (pending_beats.size() != 0 && !steady_flow &&
                      $urandom_range(0, 9) == 0) begin
            start    <= 1'b0;
            hold_off <= $urandom_range(0, 6);
         end else if (pending_beats.size() != 0) begin
            beat = pending_beats.pop_front();
            on_port        <= beat;
            req_data_lane0 <= beat.bytes[0];
            req_data_lane1 <= beat.bytes[1];
            req_data_lane2 <= beat.bytes[2];
            req_data_lane3 <= beat.bytes[3];
            req_data_lane4 <= beat.bytes[4];
            req_data_lane5 <= beat.bytes[5];
            req_data_lane6 <= beat.bytes[6];
            req_data_lane7 <= beat.bytes[7];
            req_in_last    <= beat.last;
            start          <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_parity
      logic [gfpe_pkg::ParityLanes-1:0][7:0] got;
      parity_due_type  head;
      parity_beat_type want;
      got = {rsp_parity_lane3, rsp_parity_lane2, rsp_parity_lane1, rsp_parity_lane0};
      if (!reset && rsp_valid) begin
         // An expectation pushed at this very edge belongs to a beat still in flight.
         if (parity_due.size() == 0 || parity_due[0].accepted_at == $time) begin
            $error("parity beat with nothing outstanding: %h last %b", got, rsp_out_last);
            mismatch_count++;
         end else begin
            head = parity_due.pop_front();
            want = head.value;
            for (int r = 0; r < gfpe_pkg::ParityLanes; r++) begin
               if (got[r] !== want.parity[r]) begin
                  $error("parity_lane%0d: expected %02h, got %02h", r, want.parity[r], got[r]);
                  mismatch_count++;
               end
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %b, got %b", want.last, rsp_out_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : run_phases
      int random_count;
      int n;
      random_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset values: all rows zero, so every parity is zero.
      queue_beat({8{8'hFF}}, 1'b1);
      queue_random_beat();
      wait_idle();

      // Plain XOR row, all-ones row, all-zero row and a random row over every lane.
      set_registers(64'd8, 64'd4, 64'h0101_0101_0101_0101, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h0, {$urandom, $urandom}, 64'h1D, 1'b0);
      queue_beat({8{8'h00}}, 1'b0);
      queue_beat({8{8'hFF}}, 1'b1);
      queue_beat({8{8'h80}}, 1'b0);
      queue_beat({8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01}, 1'b1);
      queue_random_beat();
      wait_idle();

      // One data lane, one parity row, degenerate polynomial.
      set_registers(64'd1, 64'd1, random_row(), random_row(), random_row(), random_row(),
                    64'h00, 1'b0);
      queue_beat({8{8'hFF}}, 1'b0);
      queue_random_beat();
      queue_random_beat();
      wait_idle();

      // Zero counts, with a write to an index that maps to nothing.
      set_registers(64'd0, 64'd0, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 64'h1D, 1'b1);
      queue_beat({8{8'hFF}}, 1'b1);
      queue_random_beat();
      wait_idle();

      // Counts at their field maxima saturate to the lane limits.
      set_registers(64'd15, 64'd7, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 64'hFF, 1'b0);
      queue_beat({8{8'h80}}, 1'b0);
      queue_random_beat();
      queue_random_beat();
      wait_idle();

      set_registers(64'd9, 64'd5, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(0, 255)),
                    1'b0);
      queue_random_beat();
      queue_random_beat();
      wait_idle();

      // Row 1 has coefficients only on lanes that are switched off.
      set_registers(64'd3, 64'd2, {$urandom, $urandom}, 64'hA5C3_7E01_FF00_0000,
                    {$urandom, $urandom}, {$urandom, $urandom}, 64'h1D, 1'b0);
      queue_random_beat();
      queue_random_beat();
      wait_idle();

      while (random_count < RandomBeats) begin
         randomize_registers($urandom_range(0, 5) == 0);
         n = $urandom_range(10, 70);
         if (n > RandomBeats - random_count) begin
            n = RandomBeats - random_count;
         end
         steady_flow = (random_count >= RandomBeats - 120);
         repeat (n) queue_random_beat();
         random_count += n;
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
